FILE: src/vha_pkg.sv
package vha_pkg;

    localparam int SPEED_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD_BITS   = 8;
    localparam int TABLE_LEN    = 24;
    localparam int STEP_W       = $clog2(TABLE_LEN);
    localparam int HEADING_W    = 16;

    // |v| << GUARD_BITS plus headroom for the CORDIC gain and the sign
    localparam int DW = SPEED_WIDTH + 1 + GUARD_BITS + 3;
    // Q.24 angles: accumulator (signed), clamped angle, full-circle angle
    localparam int ZW = 27;
    localparam int AW = 25;
    localparam int FW = 27;
    localparam int TAB_W = 24;

    localparam logic [HEADING_W-1:0] HALF_PI_Q13       = 16'd12868;
    localparam logic [HEADING_W-1:0] PI_Q13            = 16'd25736;
    localparam logic [HEADING_W-1:0] THREE_HALF_PI_Q13 = 16'd38604;
    localparam logic [HEADING_W-1:0] TWO_PI_Q13        = 16'd51472;

    localparam logic [FW-1:0] HALF_PI_Q24 = 27'd26353589;
    localparam logic [FW-1:0] PI_Q24      = 27'd52707179;
    localparam logic [FW-1:0] TWO_PI_Q24  = 27'd105414357;
    localparam logic [FW-1:0] ROUND_Q24   = 27'd1024;

    typedef struct packed {
        logic load;
        logic iter;
        logic map;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic last_step;
    } t_status;

    // atan(2^-i) in units of 2^-24 rad
    function automatic logic [TAB_W-1:0] atan_q24(input logic [STEP_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/vha_ctrl.sv
module vha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  vha_pkg::t_status i_status,
    output vha_pkg::t_cmd    o_cmd
);
    import vha_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_MAP,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd      = '0;
        cmd.load = (r_state == ST_IDLE) && i_valid;
        cmd.iter = (r_state == ST_ITER);
        cmd.map  = (r_state == ST_MAP);
        cmd.emit = (r_state == ST_EMIT) && (!r_out_valid || !i_stall);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = i_status.special ? ST_EMIT : ST_ITER;
            end
            ST_ITER: begin
                if (i_status.last_step) n_state = ST_MAP;
            end
            ST_MAP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (cmd.emit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.emit) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!r_out_valid || !i_stall))
        else $error("word loaded over a stalled output");

    a_last_step_maps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ITER) && i_status.last_step |=> (r_state == ST_MAP))
        else $error("iteration did not end after last step");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> (r_state != ST_IDLE))
        else $error("accepted word left controller idle");

endmodule

FILE: src/vha_dpath.sv
module vha_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [vha_pkg::SPEED_WIDTH-1:0] i_x_speed,
    input  logic signed [vha_pkg::SPEED_WIDTH-1:0] i_y_speed,
    input  vha_pkg::t_cmd                      i_cmd,
    output vha_pkg::t_status                   o_status,
    output logic [vha_pkg::HEADING_W-1:0]      o_heading,
    output logic                               o_held
);
    import vha_pkg::*;

    logic signed [DW-1:0]     r_x, r_y;
    logic signed [ZW-1:0]     r_z;
    logic [STEP_W-1:0]        r_step;
    logic                     r_xneg, r_yneg;
    logic [HEADING_W-1:0]     r_res, r_last, r_out_heading;
    logic                     r_held, r_out_held;

    logic                     x_zero, y_zero;
    logic [SPEED_WIDTH:0]     x_ext, y_ext, ax, ay;
    logic [HEADING_W-1:0]     special_res;
    logic signed [DW-1:0]     dx, dy;
    logic signed [ZW-1:0]     dz;
    logic [AW-1:0]            a_clamp;
    logic [FW-1:0]            full, rounded;
    logic [HEADING_W-1:0]     q13;

    assign x_zero = (i_x_speed == '0);
    assign y_zero = (i_y_speed == '0);
    assign x_ext  = {i_x_speed[SPEED_WIDTH-1], i_x_speed};
    assign y_ext  = {i_y_speed[SPEED_WIDTH-1], i_y_speed};
    assign ax     = x_ext[SPEED_WIDTH] ? (~x_ext + 1'b1) : x_ext;
    assign ay     = y_ext[SPEED_WIDTH] ? (~y_ext + 1'b1) : y_ext;

    always_comb begin
        if (x_zero && y_zero)
            special_res = r_last;
        else if (y_zero)
            special_res = i_x_speed[SPEED_WIDTH-1] ? PI_Q13 : '0;
        else
            special_res = i_y_speed[SPEED_WIDTH-1] ? THREE_HALF_PI_Q13 : HALF_PI_Q13;
    end

    assign o_status.special   = x_zero || y_zero;
    assign o_status.last_step = (r_step == STEP_W'(CORDIC_STEPS - 1));

    // arithmetic shift of a signed value rounds toward minus infinity
    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;
    assign dz = signed'({{(ZW-TAB_W){1'b0}}, atan_q24(r_step)});

    always_comb begin
        if (r_z[ZW-1])
            a_clamp = '0;
        else if (r_z > signed'(ZW'(HALF_PI_Q24)))
            a_clamp = AW'(HALF_PI_Q24);
        else
            a_clamp = r_z[AW-1:0];
    end

    always_comb begin
        if (!r_xneg)
            full = r_yneg ? (TWO_PI_Q24 - FW'(a_clamp)) : FW'(a_clamp);
        else
            full = r_yneg ? (PI_Q24 + FW'(a_clamp)) : (PI_Q24 - FW'(a_clamp));
        rounded = full + ROUND_Q24;
        q13     = rounded[FW-1:11];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= signed'(DW'({ax, {GUARD_BITS{1'b0}}}));
            r_y    <= signed'(DW'({ay, {GUARD_BITS{1'b0}}}));
            r_z    <= '0;
            r_step <= '0;
            r_xneg <= i_x_speed[SPEED_WIDTH-1];
            r_yneg <= i_y_speed[SPEED_WIDTH-1];
            r_res  <= special_res;
            r_held <= x_zero && y_zero;
        end else if (i_cmd.iter) begin
            if (!r_y[DW-1]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + dz;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - dz;
            end
            r_step <= r_step + 1'b1;
        end else if (i_cmd.map) begin
            r_res <= (q13 >= TWO_PI_Q13) ? '0 : q13;
        end
        if (i_cmd.emit) begin
            r_out_heading <= r_res;
            r_out_held    <= r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_cmd.emit && !r_held) begin
            r_last <= r_res;
        end
    end

    assign o_heading = r_out_heading;
    assign o_held    = r_out_held;

    a_map_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.map |=> (r_res < TWO_PI_Q13))
        else $error("mapped heading not below two pi");

    a_last_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && !r_held |=> (r_last == r_out_heading))
        else $error("last heading not updated with emitted word");

endmodule

FILE: src/velocity_heading_angle_unit.sv
// Four-quadrant heading of a signed velocity vector, unsigned Q3.13 radians
// in [0, 2*pi). One word at a time. For a general vector the result reaches
// the output register after 16 CORDIC vectoring iterations on one shared
// shift-add unit, then the quadrant map and round, then the output load.
// i_valid is taken again in the cycle after the output load. A vector on an
// axis or a zero vector skips the iterations and the map: its result goes
// from accept straight to the output load. A zero vector repeats the last
// heading (0 after reset) with o_held set. The output register holds a
// finished word while i_stall is high. One more word is accepted meanwhile,
// and it waits in the core until the output register is free. Such a wait
// delays the output load and the next accept.
module velocity_heading_angle_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [vha_pkg::SPEED_WIDTH-1:0] i_x_speed,
    input  logic signed [vha_pkg::SPEED_WIDTH-1:0] i_y_speed,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [vha_pkg::HEADING_W-1:0]         o_heading,
    output logic                                  o_held
);
    import vha_pkg::*;

    t_cmd    cmd;
    t_status status;

    vha_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vha_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_x_speed (i_x_speed),
        .i_y_speed (i_y_speed),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_heading (o_heading),
        .o_held    (o_held)
    );

endmodule
